@@ rtl/msd_pkg.sv @@
// Package for the message stream deframer: constants, phase codes and the result struct.
package msd_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int HDR_SIZE_BITS   = 5;
	localparam int EXT_SIZE_BITS   = 7;
	localparam logic [6:0] SHIFT_MAX = 7'd127;
	localparam int MORE_BIT_POS    = 7;
	localparam logic [1:0] TYPE_MASK = 2'h3;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_COMPRESSED_MASK = 1'b0;

	typedef enum logic [1:0] {
		PH_OPTIONS = 2'd0,
		PH_HEADER  = 2'd1,
		PH_EXT     = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  message_type;
		logic [7:0]  options_value;
		logic        is_compressed;
		logic [31:0] message_length;
		logic        length_known;
		logic        end_of_message;
		logic        length_overflow;
	} result_t;

endpackage

@@ rtl/msd_ifs.sv @@
// Stream interfaces: raw byte input channel and tagged result channel.
interface msd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

interface msd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  message_type;
	logic [7:0]  options_value;
	logic        is_compressed;
	logic [31:0] message_length;
	logic        length_known;
	logic        end_of_message;
	logic        length_overflow;

	modport source(output valid, output byte_kind, output payload_byte, output message_type,
		output options_value, output is_compressed, output message_length,
		output length_known, output end_of_message, output length_overflow, input ready);
	modport sink(input valid, input byte_kind, input payload_byte, input message_type,
		input options_value, input is_compressed, input message_length,
		input length_known, input end_of_message, input length_overflow, output ready);
endinterface

@@ rtl/msd_decode.sv @@
// Framing state machine: classifies one byte per step and builds its tagged result.
module msd_decode #(
	parameter int LENGTH_BITS = msd_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic [7:0]       mask,
	output msd_pkg::result_t res
);
	import msd_pkg::*;

	localparam int EXT_W = LENGTH_BITS + EXT_SIZE_BITS;
	localparam logic [6:0] LEN_SH = 7'(LENGTH_BITS);

	phase_t                   phase_q, phase_d;
	logic [7:0]               opts_q, opts_d;
	logic [1:0]               type_q, type_d;
	logic [LENGTH_BITS-1:0]   accum_q, accum_d;
	logic [6:0]               shift_q, shift_d;
	logic [LENGTH_BITS-1:0]   count_q, count_d;
	logic                     ovf_q, ovf_d;
	logic                     known, eom;
	logic [6:0]               ext_v;
	logic [EXT_W-1:0]         shifted;
	logic [7:0]               sh_sum;
	logic [63:0]              accum64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPTIONS;
			opts_q  <= '0;
			type_q  <= '0;
			accum_q <= '0;
			shift_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			opts_q  <= opts_d;
			type_q  <= type_d;
			accum_q <= accum_d;
			shift_q <= shift_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

	assign ext_v   = byte_in[6:0];
	assign shifted = EXT_W'(ext_v) << shift_q;
	assign sh_sum  = {1'b0, shift_q} + 8'(EXT_SIZE_BITS);

	always_comb begin
		phase_d = phase_q;
		opts_d  = opts_q;
		type_d  = type_q;
		accum_d = accum_q;
		shift_d = shift_q;
		count_d = count_q;
		ovf_d   = ovf_q;
		known   = 1'b0;
		eom     = 1'b0;
		case (phase_q)
			PH_OPTIONS: begin
				opts_d  = byte_in;
				type_d  = '0;
				accum_d = '0;
				shift_d = '0;
				count_d = '0;
				ovf_d   = 1'b0;
				phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				type_d  = byte_in[1:0] & TYPE_MASK;
				accum_d = LENGTH_BITS'(byte_in[6:2]);
				shift_d = 7'(HDR_SIZE_BITS);
				count_d = '0;
				if (byte_in[MORE_BIT_POS]) begin
					phase_d = PH_EXT;
				end else begin
					known = 1'b1;
					if (accum_d == '0) begin
						eom     = 1'b1;
						phase_d = PH_OPTIONS;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_EXT: begin
				accum_d = accum_q | shifted[LENGTH_BITS-1:0];
				if ((shift_q >= LEN_SH) ? (|ext_v) : (|shifted[EXT_W-1:LENGTH_BITS])) begin
					ovf_d = 1'b1;
				end
				shift_d = (sh_sum > {1'b0, SHIFT_MAX}) ? SHIFT_MAX : sh_sum[6:0];
				if (!byte_in[MORE_BIT_POS]) begin
					known = 1'b1;
					if (accum_d == '0) begin
						eom     = 1'b1;
						phase_d = PH_OPTIONS;
					end else begin
						count_d = '0;
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				count_d = count_q + LENGTH_BITS'(1);
				if (count_d == accum_q) begin
					eom     = 1'b1;
					phase_d = PH_OPTIONS;
				end
			end
			default: begin
				phase_d = PH_OPTIONS;
			end
		endcase
	end

	assign accum64 = 64'(accum_d);

	always_comb begin
		res.byte_kind       = phase_q;
		res.payload_byte    = byte_in;
		res.message_type    = type_d;
		res.options_value   = opts_d;
		res.is_compressed   = |(opts_d & mask);
		res.message_length  = accum64[31:0];
		res.length_known    = known;
		res.end_of_message  = eom;
		res.length_overflow = ovf_d;
	end

endmodule

@@ rtl/message_stream_deframer_core.sv @@
// Message stream deframer top level: input register, decoder, result register, APB register.
// A byte accepted into the input register is decoded and its result is captured in the
// result register; both stall while a held result is not taken.
// Throughput: one byte per cycle unless stalled; state updates in the single decode stage.
// Reset (arst_n low, asynchronous): awaiting an options byte, decode state zero, mask 0x01.
module message_stream_deframer_core #(
	parameter int LENGTH_BITS = msd_pkg::LENGTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	msd_byte_if.sink                    stream,
	msd_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msd_pkg::ADDR_W-1:0]  paddr,
	input  logic [msd_pkg::DATA_W-1:0]  pwdata,
	output logic [msd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import msd_pkg::*;

	logic [7:0] mask_q;
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       out_valid_q;
	result_t    res_d, res_q;
	logic       advance;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_COMPRESSED_MASK);
	assign prdata  = reg_sel ? DATA_W'(mask_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 8'h01;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mask_q <= pwdata[7:0];
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	msd_decode #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.byte_in(byte_s1),
		.mask   (mask_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.byte_kind       = res_q.byte_kind;
	assign result.payload_byte    = res_q.payload_byte;
	assign result.message_type    = res_q.message_type;
	assign result.options_value   = res_q.options_value;
	assign result.is_compressed   = res_q.is_compressed;
	assign result.message_length  = res_q.message_length;
	assign result.length_known    = res_q.length_known;
	assign result.end_of_message  = res_q.end_of_message;
	assign result.length_overflow = res_q.length_overflow;

`ifndef ASSERT_OFF
	a_known_on_size_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.length_known |->
		result.byte_kind == PH_HEADER || result.byte_kind == PH_EXT)
		else $error("length_known on a byte that is not a size byte");

	a_payload_end_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.end_of_message && result.byte_kind == PH_PAYLOAD |->
		!result.length_known)
		else $error("payload end flagged together with size completion");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("input stalled without a blocked result");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("decoded byte did not reach the output register");
`endif

endmodule
